@@ src/lkv_pkg.sv @@
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants for the LRU key-value cache
// Entry layout, per-beat control to the cell row and operation codes.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  // common width for comparing the fill count against the capacity register
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_t;

  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  // broadcast to every cell for the beat being taken
  typedef struct packed {
    logic fire;   // a beat is accepted this cycle
    logic get;    // operation is a lookup
    logic hit;    // key found somewhere in the row
    logic evict;  // miss put with the fill count at capacity: drop the least recent entry
  } cell_ctl_t;

endpackage

@@ src/lkv_in_if.sv @@
// ----------------------------------------------------------------------------
// lkv_in_if: request channel of the LRU key-value cache
// Valid/ready handshake carrying operation, key and value.
// ----------------------------------------------------------------------------
interface lkv_in_if;
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic signed [lkv_pkg::KEY_W-1:0] key;
  logic signed [lkv_pkg::VAL_W-1:0] value;

  modport source (output valid, output func, output key, output value, input ready);
  modport sink   (input valid, input func, input key, input value, output ready);
endinterface

@@ src/lkv_out_if.sv @@
// ----------------------------------------------------------------------------
// lkv_out_if: response channel of the LRU key-value cache
// Valid/ready handshake carrying hit flag, read value and eviction report.
// ----------------------------------------------------------------------------
interface lkv_out_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic signed [lkv_pkg::VAL_W-1:0] read_value;
  logic                            evicted;
  logic signed [lkv_pkg::KEY_W-1:0] evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

@@ src/lkv_cell.sv @@
// ----------------------------------------------------------------------------
// lkv_cell: one recency slot of the LRU key-value cache
// Holds one entry, compares it with the request key and takes its
// neighbour's entry when the row shifts towards the least recent end.
// ----------------------------------------------------------------------------
module lkv_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lkv_pkg::cell_ctl_t               ctl,
  input  logic signed [lkv_pkg::KEY_W-1:0] req_key,
  input  lkv_pkg::entry_t                  prev,
  input  logic                             next_valid,
  input  logic                             seen_in,
  output logic                             seen_out,
  input  logic signed [lkv_pkg::VAL_W-1:0] hit_val_in,
  output logic signed [lkv_pkg::VAL_W-1:0] hit_val_out,
  input  logic signed [lkv_pkg::KEY_W-1:0] evk_in,
  output logic signed [lkv_pkg::KEY_W-1:0] evk_out,
  output lkv_pkg::entry_t                  self
);

  logic                             valid_r, valid_nxt;
  logic signed [lkv_pkg::KEY_W-1:0] key_r, key_nxt;
  logic signed [lkv_pkg::VAL_W-1:0] val_r, val_nxt;
  logic                             match;
  logic                             last;
  logic                             shift;

  assign match = valid_r && (key_r == req_key);
  // least recent entry: valid with nothing valid behind it
  assign last  = valid_r && !next_valid;

  assign seen_out    = seen_in | match;
  assign hit_val_out = hit_val_in | (match ? val_r : '0);
  assign evk_out     = evk_in | (last ? key_r : '0);

  assign self.valid = valid_r;
  assign self.key   = key_r;
  assign self.value = val_r;

  always_comb begin
    shift = 1'b0;
    if (ctl.fire) begin
      if (ctl.hit) begin
        // advance every slot up to and including the first match
        shift = !seen_in;
      end else if (!ctl.get) begin
        shift = ctl.evict ? valid_r : prev.valid;
      end
    end
    valid_nxt = shift ? prev.valid : valid_r;
    key_nxt   = shift ? prev.key   : key_r;
    val_nxt   = shift ? prev.value : val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

endmodule

@@ src/lru_key_value_cache_unit.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit: fully associative key-value cache, LRU replacement
// Row of slot cells ordered by recency; slot 0 is the most recent entry.
//
//   channel   dir  handshake          payload
//   in_ch     in   valid/ready        func, key, value
//   out_ch    out  valid/ready        hit, read_value, evicted, evicted_key
//   cfg_*     in   write enable only  capacity_in_use (5 bits)
//
// One beat per cycle: compare, promote and shift across the cell row all
// complete in the accepting cycle, and the response is registered.
// A new request is taken whenever the response register is empty or is
// being drained in the same cycle; a stalled response holds the input off.
// Synchronous reset empties every slot and sets capacity to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  lkv_in_if.sink                      in_ch,
  lkv_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0]   cfg_wdata
);

  localparam int E = lkv_pkg::ENTRIES;

  logic [lkv_pkg::CAP_W-1:0] cap_r;
  logic [lkv_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [lkv_pkg::CMP_W-1:0] eff_cap;
  logic [lkv_pkg::CMP_W-1:0] count_ext;

  logic                             out_valid_r;
  logic                             hit_r;
  logic signed [lkv_pkg::VAL_W-1:0] read_value_r;
  logic                             evicted_r;
  logic signed [lkv_pkg::KEY_W-1:0] evicted_key_r;

  logic                             fire;
  logic                             is_get;
  logic                             any_hit;
  logic                             do_evict;
  lkv_pkg::cell_ctl_t               ctl;
  lkv_pkg::entry_t                  new_entry;

  logic                             seen    [E+1];
  logic signed [lkv_pkg::VAL_W-1:0] hit_val [E+1];
  logic signed [lkv_pkg::KEY_W-1:0] evk     [E+1];
  lkv_pkg::entry_t                  cells   [E];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;
  assign is_get      = (in_ch.func == lkv_pkg::FUNC_GET);

  // capacity register clamped to 1..ENTRIES
  always_comb begin
    eff_cap = lkv_pkg::CMP_W'(cap_r);
    if (cap_r == '0) begin
      eff_cap = lkv_pkg::CMP_W'(1);
    end
    if (eff_cap > lkv_pkg::CMP_W'(E)) begin
      eff_cap = lkv_pkg::CMP_W'(E);
    end
  end

  assign count_ext = lkv_pkg::CMP_W'(count_r);
  assign any_hit   = seen[E];
  assign do_evict  = !is_get && !any_hit && (count_ext >= eff_cap);

  assign ctl.fire  = fire;
  assign ctl.get   = is_get;
  assign ctl.hit   = any_hit;
  assign ctl.evict = do_evict;

  assign new_entry.valid = 1'b1;
  assign new_entry.key   = in_ch.key;
  assign new_entry.value = is_get ? hit_val[E] : in_ch.value;

  assign seen[0]    = 1'b0;
  assign hit_val[0] = '0;
  assign evk[0]     = '0;

  for (genvar i = 0; i < E; i++) begin : g_cell
    lkv_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .req_key     (in_ch.key),
      .prev        ((i == 0) ? new_entry : cells[(i == 0) ? 0 : i-1]),
      .next_valid  ((i == E-1) ? 1'b0 : cells[(i == E-1) ? i : i+1].valid),
      .seen_in     (seen[i]),
      .seen_out    (seen[i+1]),
      .hit_val_in  (hit_val[i]),
      .hit_val_out (hit_val[i+1]),
      .evk_in      (evk[i]),
      .evk_out     (evk[i+1]),
      .self        (cells[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (fire && !is_get && !any_hit && !do_evict) begin
      count_nxt = count_r + lkv_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= lkv_pkg::CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      count_r <= count_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // response payload, held while the beat is stalled
  always_ff @(posedge clk) begin
    if (fire) begin
      hit_r         <= any_hit;
      read_value_r  <= is_get ? (any_hit ? hit_val[E] : -32'sd1) : '0;
      evicted_r     <= do_evict;
      evicted_key_r <= do_evict ? evk[E] : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = hit_r;
  assign out_ch.read_value  = read_value_r;
  assign out_ch.evicted     = evicted_r;
  assign out_ch.evicted_key = evicted_key_r;

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the LRU key-value cache unit
// Drives get and put beats with random gaps and back-pressure, predicts each
// response from an in-bench recency-ordered copy of the store (typed rows from
// the table) and checks every response field. A short directed table opens
// the run, then random phases follow, each under its own capacity setting.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT        = 300000;
  localparam int PHASE_ITEMS  = 81;
  localparam int POOL_MAX     = 24;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 60;

  typedef logic signed [lkv_pkg::KEY_W-1:0] key_t;
  typedef logic signed [lkv_pkg::VAL_W-1:0] val_t;

  typedef struct packed {
    logic hit;
    val_t read_value;
    logic evicted;
    key_t evicted_key;
  } lookup_res_t;

  typedef enum logic {
    ROW_OP  = 1'b0,
    ROW_CAP = 1'b1
  } row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    lkv_pkg::func_t            func;
    key_t                      key;
    val_t                      value;
    logic [lkv_pkg::CAP_W-1:0] cap;
    logic                      typed;
    lookup_res_t               res;
  } stim_row_t;

  localparam lookup_res_t MISS_GET = '{1'b0, -32'sd1, 1'b0, 32'sd0};
  localparam lookup_res_t NEW_PUT  = '{1'b0, 32'sd0, 1'b0, 32'sd0};
  localparam lookup_res_t HIT_PUT  = '{1'b1, 32'sd0, 1'b0, 32'sd0};
  localparam lookup_res_t NONE     = '{1'b0, 32'sd0, 1'b0, 32'sd0};

  localparam int DIR_ROWS = 26;

  stim_row_t dir_table [DIR_ROWS] = '{
    '{ROW_OP,  lkv_pkg::FUNC_GET, 32'sd0,         32'sd0,         5'd0,  1'b1, MISS_GET},
    '{ROW_OP,  lkv_pkg::FUNC_GET, 32'sh8000_0000, 32'sd0,         5'd0,  1'b1, MISS_GET},
    '{ROW_OP,  lkv_pkg::FUNC_PUT, 32'sh7fff_ffff, 32'sh8000_0000, 5'd0,  1'b1, NEW_PUT},
    '{ROW_OP,  lkv_pkg::FUNC_GET, 32'sh7fff_ffff, 32'sd0,         5'd0,  1'b1,
      '{1'b1, 32'sh8000_0000, 1'b0, 32'sd0}},
    '{ROW_OP,  lkv_pkg::FUNC_PUT, 32'sh8000_0000, 32'sh7fff_ffff, 5'd0,  1'b1, NEW_PUT},
    '{ROW_OP,  lkv_pkg::FUNC_PUT, 32'sh7fff_ffff, -32'sd1,        5'd0,  1'b1, HIT_PUT},
    '{ROW_OP,  lkv_pkg::FUNC_GET, 32'sh8000_0000, 32'sh1234_5678, 5'd0,  1'b1,
      '{1'b1, 32'sh7fff_ffff, 1'b0, 32'sd0}},
    // a hit whose stored value happens to be all ones
    '{ROW_OP,  lkv_pkg::FUNC_GET, 32'sh7fff_ffff, 32'sd0,         5'd0,  1'b1,
      '{1'b1, -32'sd1, 1'b0, 32'sd0}},
    // capacity zero acts as one, and is already below the fill count
    '{ROW_CAP, lkv_pkg::FUNC_GET, 32'sd0,         32'sd0,         5'd0,  1'b0, NONE},
    '{ROW_OP,  lkv_pkg::FUNC_PUT, 32'sd1,         32'sd1,         5'd0,  1'b0, NONE},
    '{ROW_OP,  lkv_pkg::FUNC_GET, 32'sh8000_0000, 32'sd0,         5'd0,  1'b0, NONE},
    '{ROW_OP,  lkv_pkg::FUNC_PUT, 32'sd2,         32'sd2,         5'd0,  1'b0, NONE},
    '{ROW_OP,  lkv_pkg::FUNC_PUT, 32'sd2,         32'sd3,         5'd0,  1'b0, NONE},
    '{ROW_OP,  lkv_pkg::FUNC_GET, 32'sd1,         32'sd0,         5'd0,  1'b0, NONE},
    // register above the store size saturates
    '{ROW_CAP, lkv_pkg::FUNC_GET, 32'sd0,         32'sd0,         5'd31, 1'b0, NONE},
    '{ROW_OP,  lkv_pkg::FUNC_PUT, 32'sd0,         32'sd0,         5'd0,  1'b0, NONE},
    '{ROW_OP,  lkv_pkg::FUNC_PUT, 32'sd10,        -32'sd10,       5'd0,  1'b0, NONE},
    '{ROW_OP,  lkv_pkg::FUNC_PUT, -32'sd11,       32'sd11,        5'd0,  1'b0, NONE},
    '{ROW_OP,  lkv_pkg::FUNC_PUT, 32'sh5555_5555, 32'sh2aaa_aaaa, 5'd0,  1'b0, NONE},
    '{ROW_OP,  lkv_pkg::FUNC_PUT, 32'sh2aaa_aaaa, 32'sh5555_5555, 5'd0,  1'b0, NONE},
    '{ROW_OP,  lkv_pkg::FUNC_PUT, 32'sd13,        32'sd13,        5'd0,  1'b0, NONE},
    '{ROW_OP,  lkv_pkg::FUNC_GET, 32'sd2,         32'sd0,         5'd0,  1'b0, NONE},
    // lowered below the fill count: each new key evicts one, count holds
    '{ROW_CAP, lkv_pkg::FUNC_GET, 32'sd0,         32'sd0,         5'd2,  1'b0, NONE},
    '{ROW_OP,  lkv_pkg::FUNC_PUT, 32'sd77,        32'sd78,        5'd0,  1'b0, NONE},
    '{ROW_OP,  lkv_pkg::FUNC_GET, 32'sh5555_5555, 32'sd0,         5'd0,  1'b0, NONE},
    '{ROW_OP,  lkv_pkg::FUNC_PUT, 32'sd13,        -32'sd2,        5'd0,  1'b0, NONE}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [lkv_pkg::CAP_W-1:0] cfg_wdata;

  lkv_in_if  in_ch();
  lkv_out_if out_ch();

  lru_key_value_cache_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // in-bench copy of the store: slot 0 is the most recent entry
  key_t                      lru_key [lkv_pkg::ENTRIES];
  val_t                      lru_val [lkv_pkg::ENTRIES];
  int                        lru_count;
  logic [lkv_pkg::CAP_W-1:0] cap_reg;

  lookup_res_t pending_q [$];
  int errors;
  int beats_sent;
  int beats_seen;
  int n_get, n_put, n_hit, n_evict, n_caps;
  bit calm;
  bit hold_long;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void move_to_front(int pos, key_t k, val_t v);
    for (int i = pos; i > 0; i--) begin
      lru_key[i] = lru_key[i-1];
      lru_val[i] = lru_val[i-1];
    end
    lru_key[0] = k;
    lru_val[0] = v;
  endfunction

  function automatic lookup_res_t cache_lookup(lkv_pkg::func_t f, key_t k, val_t v);
    lookup_res_t r;
    bit found;
    int pos;
    int n;
    int eff;
    r = '0;
    found = 1'b0;
    pos = 0;
    for (int i = 0; i < lru_count; i++) begin
      if (!found && lru_key[i] == k) begin
        found = 1'b1;
        pos = i;
      end
    end
    eff = (cap_reg == 0) ? 1 :
          ((int'(cap_reg) > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES : int'(cap_reg));
    r.hit = found;
    if (f == lkv_pkg::FUNC_GET) begin
      if (found) begin
        r.read_value = lru_val[pos];
        move_to_front(pos, k, lru_val[pos]);
      end else begin
        r.read_value = -32'sd1;
      end
    end else if (found) begin
      move_to_front(pos, k, v);
    end else begin
      n = lru_count;
      if (n >= eff) begin
        r.evicted = 1'b1;
        r.evicted_key = lru_key[n-1];
        n = n - 1;
      end
      move_to_front(n, k, v);
      lru_count = n + 1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("[%0t] response %0d %s: got %h, want %h", $realtime, beats_seen, what, got,
             want);
  endtask

  // one request beat; valid stays high into the next call unless a gap is taken
  task automatic send_request(lkv_pkg::func_t f, key_t k, val_t v, logic typed,
                              lookup_res_t res);
    int gap;
    lookup_res_t r;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.key   <= k;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    r = cache_lookup(f, k, v);
    pending_q.push_back(typed ? res : r);
    beats_sent++;
    if (f == lkv_pkg::FUNC_GET) n_get++;
    else n_put++;
  endtask

  // write the capacity only once every response is home
  task automatic set_capacity(logic [lkv_pkg::CAP_W-1:0] c);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cap_reg = c;
    n_caps++;
  endtask

  // response side: random stall bursts, plus one long hold-off
  initial begin
    int burst;
    burst = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ch.ready <= 1'b0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else if (burst > 0) begin
        out_ch.ready <= 1'b0;
        burst--;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        burst = $urandom_range(0, 6);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    hold_long = 1'b0;
    wait (beats_sent >= HOLD_AT);
    hold_long = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_long = 1'b0;
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d responses outstanding", LIMIT,
             pending_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    lookup_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected beat", out_ch.read_value, 32'd0);
      end else begin
        want = pending_q.pop_front();
        if (out_ch.hit !== want.hit)
          report_mismatch("hit", 32'(out_ch.hit), 32'(want.hit));
        if (out_ch.read_value !== want.read_value)
          report_mismatch("read_value", out_ch.read_value, want.read_value);
        if (out_ch.evicted !== want.evicted)
          report_mismatch("evicted", 32'(out_ch.evicted), 32'(want.evicted));
        if (out_ch.evicted_key !== want.evicted_key)
          report_mismatch("evicted_key", out_ch.evicted_key, want.evicted_key);
      end
      if (out_ch.hit === 1'b1) n_hit++;
      if (out_ch.evicted === 1'b1) n_evict++;
      beats_seen++;
    end
  end

  initial begin
    int cap_plan [8];
    key_t pool [POOL_MAX];
    int pool_n;
    int eff;
    lkv_pkg::func_t f;
    key_t k;
    cap_plan = '{16, 1, 5, 0, 31, 3, 12, 16};
    errors = 0;
    beats_sent = 0;
    beats_seen = 0;
    n_get = 0;
    n_put = 0;
    n_hit = 0;
    n_evict = 0;
    n_caps = 0;
    calm = 1'b0;
    lru_count = 0;
    cap_reg = lkv_pkg::CAP_RESET;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.func  <= lkv_pkg::FUNC_GET;
    in_ch.key   <= '0;
    in_ch.value <= '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CAP)
        set_capacity(dir_table[i].cap);
      else
        send_request(dir_table[i].func, dir_table[i].key, dir_table[i].value,
                     dir_table[i].typed, dir_table[i].res);
    end

    foreach (cap_plan[p]) begin
      set_capacity(lkv_pkg::CAP_W'(cap_plan[p]));
      calm = (p == 7);
      eff = (cap_plan[p] == 0) ? 1 :
            ((cap_plan[p] > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES : cap_plan[p]);
      // a pool a little wider than the capacity keeps both hits and evictions busy
      pool_n = (eff + 4 > POOL_MAX) ? POOL_MAX : eff + 4;
      for (int j = 0; j < POOL_MAX; j++)
        pool[j] = $urandom;
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        f = lkv_pkg::func_t'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 85)
          k = pool[$urandom_range(0, pool_n - 1)];
        else
          k = $urandom;
        send_request(f, k, val_t'($urandom), 1'b0, NONE);
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_q.size() != 0)
      report_mismatch("left over", pending_q.size(), 32'd0);

    $display("ran %0d gets and %0d puts under %0d capacity settings", n_get, n_put, n_caps);
    $display("saw %0d hits and %0d evictions, %0d errors", n_hit, n_evict, errors);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
